FILE: rtl/core/pcle_pkg.sv
// Package for the pilot LS channel estimator: widths, codes and the command
// beat that travels from the front to the back.
// No dependencies.
package pcle_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int FRAC_BITS       = SAMPLE_BITS - 2;
    localparam int EST_BITS        = SAMPLE_BITS + 2;
    localparam int IDX_BITS        = 10;
    localparam int N_BITS          = 11;
    localparam int S_BITS          = 5;
    localparam int PH_BITS         = 4;
    localparam int MAX_SUBCARRIERS = 1024;
    localparam int MAX_SPACING     = 16;

    localparam int DVD_BITS  = 46;
    localparam int DVS_BITS  = 32;
    localparam int QUO_BITS  = 19;
    localparam int STEP_BITS = 6;

    localparam logic CFG_NUM_SC  = 1'b0;
    localparam logic CFG_SPACING = 1'b1;

    localparam logic KIND_HOLD  = 1'b0;
    localparam logic KIND_PILOT = 1'b1;

    typedef struct packed {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] rx_re;
        logic signed [SAMPLE_BITS-1:0] rx_im;
        logic signed [SAMPLE_BITS-1:0] ref_re;
        logic signed [SAMPLE_BITS-1:0] ref_im;
        logic [IDX_BITS-1:0]           k;
        logic [S_BITS-1:0]             s;
        logic                          tail;
        logic                          last;
    } t_cmd;

endpackage

FILE: rtl/core/pcle_div.sv
// Restoring divider, one quotient bit per cycle, with an overflow flag.
// Depends on pcle_pkg.
module pcle_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pcle_pkg::DVD_BITS-1:0]  i_dividend,
    input  logic [pcle_pkg::STEP_BITS-1:0] i_steps,
    input  logic [pcle_pkg::DVS_BITS-1:0]  i_divisor,
    output logic                           o_done,
    output logic [pcle_pkg::QUO_BITS-1:0]  o_quot,
    output logic                           o_ovf,
    output logic [pcle_pkg::DVS_BITS-1:0]  o_rem
);
    import pcle_pkg::*;

    logic [STEP_BITS-1:0] r_cnt;
    logic                 r_done;
    logic [DVD_BITS-1:0]  r_dvd;
    logic [DVS_BITS-1:0]  r_rem;
    logic [DVS_BITS-1:0]  r_dvs;
    logic [QUO_BITS-1:0]  r_quo;
    logic                 r_ovf;
    logic [DVS_BITS:0]    trial;
    logic                 qbit;

    assign trial = {r_rem, r_dvd[DVD_BITS-1]};
    assign qbit  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_BITS-2:0], 1'b0};
            r_rem <= qbit ? DVS_BITS'(trial - {1'b0, r_dvs}) : trial[DVS_BITS-1:0];
            r_quo <= {r_quo[QUO_BITS-2:0], qbit};
            r_ovf <= r_ovf | r_quo[QUO_BITS-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_ovf  = r_ovf;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/pcle_fifo.sv
// Four-entry command queue between the front and the back.
// Depends on pcle_pkg.
module pcle_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  pcle_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_rd,
    output pcle_pkg::t_cmd o_data,
    output logic           o_empty
);
    import pcle_pkg::*;

    t_cmd       r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       wr_ok;
    logic       rd_ok;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {2'b0, wr_ok} - {2'b0, rd_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/core/pcle_front.sv
// Front part: configuration registers, frame position tracking and
// classification of each input beat into queue commands.
// Depends on pcle_pkg.
module pcle_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [pcle_pkg::N_BITS-1:0]         i_cfg_data,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [pcle_pkg::SAMPLE_BITS-1:0] i_rx_re,
    input  logic signed [pcle_pkg::SAMPLE_BITS-1:0] i_rx_im,
    input  logic signed [pcle_pkg::SAMPLE_BITS-1:0] i_ref_re,
    input  logic signed [pcle_pkg::SAMPLE_BITS-1:0] i_ref_im,
    input  logic                                i_q_full,
    output logic                                o_cmd_valid,
    output pcle_pkg::t_cmd                      o_cmd
);
    import pcle_pkg::*;

    logic [N_BITS-1:0]   r_n;
    logic [S_BITS-1:0]   r_s;
    logic [IDX_BITS-1:0] r_pos;
    logic [PH_BITS-1:0]  r_ph;
    logic                r_sync;
    logic [3:0]          r_scnt;
    logic [IDX_BITS-1:0] r_sk;
    logic [S_BITS-1:0]   r_srem;

    logic [N_BITS-1:0]   n_eff;
    logic [S_BITS-1:0]   s_eff;
    logic                wrap;
    logic [IDX_BITS-1:0] k;
    logic [PH_BITS-1:0]  ph;
    logic [IDX_BITS-1:0] base;
    logic                tail;
    logic                last;
    logic                accept;
    logic [N_BITS-1:0]   k1;
    logic [S_BITS-1:0]   ph1;
    logic [S_BITS:0]     strial;

    always_comb begin
        if (r_n == '0) begin
            n_eff = N_BITS'(1);
        end else if (r_n > N_BITS'(MAX_SUBCARRIERS)) begin
            n_eff = N_BITS'(MAX_SUBCARRIERS);
        end else begin
            n_eff = r_n;
        end
        if (r_s == '0) begin
            s_eff = S_BITS'(1);
        end else if (r_s > S_BITS'(MAX_SPACING)) begin
            s_eff = S_BITS'(MAX_SPACING);
        end else begin
            s_eff = r_s;
        end
    end

    assign wrap   = ({1'b0, r_pos} >= n_eff);
    assign k      = wrap ? '0 : r_pos;
    assign ph     = wrap ? '0 : r_ph;
    assign base   = k - IDX_BITS'(ph);
    assign tail   = ({2'b0, base} + {7'b0, s_eff}) >= {1'b0, n_eff};
    assign last   = ({1'b0, k} == (n_eff - 1'b1));
    assign o_full = r_sync || i_q_full;
    assign accept = i_push && !o_full;
    assign k1     = {1'b0, k} + 1'b1;
    assign ph1    = {1'b0, ph} + 1'b1;
    assign strial = {r_srem, r_sk[IDX_BITS-1]};

    assign o_cmd_valid = accept && ((ph == '0) || tail);

    always_comb begin
        o_cmd.kind   = (ph == '0) ? KIND_PILOT : KIND_HOLD;
        o_cmd.rx_re  = i_rx_re;
        o_cmd.rx_im  = i_rx_im;
        o_cmd.ref_re = i_ref_re;
        o_cmd.ref_im = i_ref_im;
        o_cmd.k      = k;
        o_cmd.s      = s_eff;
        o_cmd.tail   = tail;
        o_cmd.last   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= N_BITS'(64);
            r_s    <= S_BITS'(4);
            r_pos  <= '0;
            r_ph   <= '0;
            r_sync <= 1'b0;
            r_scnt <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NUM_SC:  r_n <= i_cfg_data;
                    CFG_SPACING: r_s <= i_cfg_data[S_BITS-1:0];
                    default:     r_n <= r_n;
                endcase
            end
            // A new spacing puts the phase back in step with the position.
            if (i_cfg_we && (i_cfg_idx == CFG_SPACING)) begin
                r_sync <= 1'b1;
                r_scnt <= 4'd10;
            end else if (r_sync) begin
                if (r_scnt == 4'd1) begin
                    r_sync <= 1'b0;
                    r_ph   <= PH_BITS'((strial >= {1'b0, s_eff}) ?
                                       strial - {1'b0, s_eff} : strial);
                end
                r_scnt <= r_scnt - 1'b1;
            end else if (accept) begin
                if (k1 >= n_eff) begin
                    r_pos <= '0;
                    r_ph  <= '0;
                end else begin
                    r_pos <= k1[IDX_BITS-1:0];
                    r_ph  <= (ph1 == s_eff) ? '0 : ph1[PH_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we && (i_cfg_idx == CFG_SPACING)) begin
            r_sk   <= r_pos;
            r_srem <= '0;
        end else if (r_sync) begin
            r_sk   <= {r_sk[IDX_BITS-2:0], 1'b0};
            r_srem <= S_BITS'((strial >= {1'b0, s_eff}) ? strial - {1'b0, s_eff} : strial);
        end
    end

endmodule

FILE: rtl/core/pcle_back.sv
// Back part: LS estimate at pilots, interpolation of the segment, hold
// estimates and the result register.
// Depends on pcle_pkg and pcle_div.
module pcle_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pcle_pkg::t_cmd                         i_cmd,
    input  logic                                   i_cmd_empty,
    output logic                                   o_cmd_pop,
    input  logic                                   i_pop,
    output logic                                   o_empty,
    output logic signed [pcle_pkg::EST_BITS-1:0]   o_est_re,
    output logic signed [pcle_pkg::EST_BITS-1:0]   o_est_im,
    output logic [pcle_pkg::IDX_BITS-1:0]          o_subcarrier_index,
    output logic                                   o_frame_end
);
    import pcle_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HOLD   = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_DSTART = 4'd5;
    localparam logic [3:0] ST_DDIV   = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_TAIL   = 4'd8;

    localparam int QW = EST_BITS + 2;

    logic [3:0] r_state;
    t_cmd       r_cmd;
    logic signed [31:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic r_neg_re, r_neg_im;
    logic signed [EST_BITS-1:0] r_h_re, r_h_im, r_prev_re, r_prev_im;
    logic signed [QW-1:0] r_q_re, r_q_im, r_dq_re, r_dq_im;
    logic [S_BITS-1:0] r_r_re, r_r_im, r_dr_re, r_dr_im;
    logic [PH_BITS-1:0] r_j;
    logic r_ov;
    logic signed [EST_BITS-1:0] r_o_re, r_o_im;
    logic [IDX_BITS-1:0] r_o_idx;
    logic r_o_last;

    logic signed [32:0] dot_re, dot_im, neg_dre, neg_dim;
    logic [31:0] mag_re, mag_im, den;
    logic signed [EST_BITS:0] d_re, d_im;
    logic [EST_BITS:0] absd_re, absd_im;
    logic div_start;
    logic [DVD_BITS-1:0] dvd_re, dvd_im;
    logic [STEP_BITS-1:0] steps;
    logic [DVS_BITS-1:0] dvs;
    logic done_re, done_im, ovf_re, ovf_im;
    logic [QUO_BITS-1:0] quo_re, quo_im;
    logic [DVS_BITS-1:0] rem_re, rem_im;
    logic out_free, out_we;
    logic signed [EST_BITS-1:0] w_re, w_im;
    logic [IDX_BITS-1:0] w_idx;
    logic w_last;
    logic signed [QW-1:0] ev_re, ev_im;
    logic [S_BITS:0] rs_re, rs_im;

    function automatic logic signed [EST_BITS-1:0] sat_q(
        input logic neg, input logic ovf, input logic [QUO_BITS-1:0] q);
        logic [QUO_BITS-1:0] lim;
        logic [QUO_BITS-1:0] v;
        lim = neg ? QUO_BITS'(1 << (EST_BITS - 1)) : QUO_BITS'((1 << (EST_BITS - 1)) - 1);
        v   = (ovf || (q > lim)) ? lim : q;
        v   = neg ? -v : v;
        return v[EST_BITS-1:0];
    endfunction

    assign dot_re  = {r_p0[31], r_p0} + {r_p1[31], r_p1};
    assign dot_im  = {r_p2[31], r_p2} - {r_p3[31], r_p3};
    assign neg_dre = -dot_re;
    assign neg_dim = -dot_im;
    assign mag_re  = dot_re[32] ? neg_dre[31:0] : dot_re[31:0];
    assign mag_im  = dot_im[32] ? neg_dim[31:0] : dot_im[31:0];
    assign den     = r_p4[31:0] + r_p5[31:0];
    assign d_re    = {r_h_re[EST_BITS-1], r_h_re} - {r_prev_re[EST_BITS-1], r_prev_re};
    assign d_im    = {r_h_im[EST_BITS-1], r_h_im} - {r_prev_im[EST_BITS-1], r_prev_im};
    assign absd_re = d_re[EST_BITS] ? -d_re : d_re;
    assign absd_im = d_im[EST_BITS] ? -d_im : d_im;

    always_comb begin
        div_start = 1'b0;
        dvd_re    = {mag_re, 14'b0};
        dvd_im    = {mag_im, 14'b0};
        steps     = STEP_BITS'(DVD_BITS);
        dvs       = den;
        if (r_state == ST_SUM) begin
            div_start = (den != '0);
        end else if (r_state == ST_DSTART) begin
            div_start = (r_cmd.k != '0);
            dvd_re    = {absd_re, 27'b0};
            dvd_im    = {absd_im, 27'b0};
            steps     = STEP_BITS'(EST_BITS + 1);
            dvs       = DVS_BITS'(r_cmd.s);
        end
    end

    pcle_div u_div_re (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_dividend(dvd_re),
        .i_steps(steps), .i_divisor(dvs), .o_done(done_re), .o_quot(quo_re),
        .o_ovf(ovf_re), .o_rem(rem_re)
    );

    pcle_div u_div_im (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_dividend(dvd_im),
        .i_steps(steps), .i_divisor(dvs), .o_done(done_im), .o_quot(quo_im),
        .o_ovf(ovf_im), .o_rem(rem_im)
    );

    assign out_free = !r_ov || i_pop;
    assign ev_re    = r_q_re + QW'((r_q_re[QW-1] && (r_r_re != '0)) ? 1 : 0);
    assign ev_im    = r_q_im + QW'((r_q_im[QW-1] && (r_r_im != '0)) ? 1 : 0);
    assign rs_re    = {1'b0, r_r_re} + {1'b0, r_dr_re};
    assign rs_im    = {1'b0, r_r_im} + {1'b0, r_dr_im};

    always_comb begin
        out_we = 1'b0;
        w_re   = r_h_re;
        w_im   = r_h_im;
        w_idx  = r_cmd.k;
        w_last = r_cmd.last;
        o_cmd_pop = (r_state == ST_IDLE) && !i_cmd_empty;
        unique case (r_state)
            ST_HOLD: begin
                out_we = out_free;
                w_re   = r_prev_re;
                w_im   = r_prev_im;
            end
            ST_EMIT: begin
                out_we = out_free;
                w_re   = ev_re[EST_BITS-1:0];
                w_im   = ev_im[EST_BITS-1:0];
                w_idx  = r_cmd.k - IDX_BITS'(r_cmd.s) + IDX_BITS'(r_j);
                w_last = 1'b0;
            end
            ST_TAIL: begin
                out_we = out_free && r_cmd.tail;
            end
            default: begin
                out_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ov      <= 1'b0;
            r_prev_re <= '0;
            r_prev_im <= '0;
        end else begin
            if (out_we) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_state <= (i_cmd.kind == KIND_PILOT) ? ST_MUL : ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_MUL: r_state <= ST_SUM;
                ST_SUM: r_state <= (den == '0) ? ST_DSTART : ST_DIV;
                ST_DIV: begin
                    if (done_re) begin
                        r_state <= ST_DSTART;
                    end
                end
                ST_DSTART: r_state <= (r_cmd.k == '0) ? ST_TAIL : ST_DDIV;
                ST_DDIV: begin
                    if (done_im) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free && ({1'b0, r_j} == (r_cmd.s - 1'b1))) begin
                        r_state <= ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    r_prev_re <= r_h_re;
                    r_prev_im <= r_h_im;
                    if (out_free || !r_cmd.tail) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_MUL) begin
            r_p0 <= r_cmd.rx_re * r_cmd.ref_re;
            r_p1 <= r_cmd.rx_im * r_cmd.ref_im;
            r_p2 <= r_cmd.rx_im * r_cmd.ref_re;
            r_p3 <= r_cmd.rx_re * r_cmd.ref_im;
            r_p4 <= r_cmd.ref_re * r_cmd.ref_re;
            r_p5 <= r_cmd.ref_im * r_cmd.ref_im;
        end
        if (r_state == ST_SUM) begin
            r_neg_re <= dot_re[32];
            r_neg_im <= dot_im[32];
            if (den == '0) begin
                r_h_re <= EST_BITS'(1 << FRAC_BITS);
                r_h_im <= '0;
            end
        end
        if ((r_state == ST_DIV) && done_re) begin
            r_h_re <= sat_q(r_neg_re, ovf_re, quo_re);
            r_h_im <= sat_q(r_neg_im, ovf_im, quo_im);
        end
        if (r_state == ST_DSTART) begin
            r_q_re <= QW'(r_prev_re);
            r_q_im <= QW'(r_prev_im);
            r_r_re <= '0;
            r_r_im <= '0;
            r_j    <= '0;
        end
        if ((r_state == ST_DDIV) && done_im) begin
            if (d_re[EST_BITS] && (rem_re[S_BITS-1:0] != '0)) begin
                r_dq_re <= -QW'(quo_re) - QW'(1);
                r_dr_re <= r_cmd.s - rem_re[S_BITS-1:0];
            end else begin
                r_dq_re <= d_re[EST_BITS] ? -QW'(quo_re) : QW'(quo_re);
                r_dr_re <= d_re[EST_BITS] ? '0 : rem_re[S_BITS-1:0];
            end
            if (d_im[EST_BITS] && (rem_im[S_BITS-1:0] != '0)) begin
                r_dq_im <= -QW'(quo_im) - QW'(1);
                r_dr_im <= r_cmd.s - rem_im[S_BITS-1:0];
            end else begin
                r_dq_im <= d_im[EST_BITS] ? -QW'(quo_im) : QW'(quo_im);
                r_dr_im <= d_im[EST_BITS] ? '0 : rem_im[S_BITS-1:0];
            end
        end
        if ((r_state == ST_EMIT) && out_free) begin
            r_j <= r_j + 1'b1;
            if (rs_re >= {1'b0, r_cmd.s}) begin
                r_r_re <= S_BITS'(rs_re - {1'b0, r_cmd.s});
                r_q_re <= r_q_re + r_dq_re + QW'(1);
            end else begin
                r_r_re <= rs_re[S_BITS-1:0];
                r_q_re <= r_q_re + r_dq_re;
            end
            if (rs_im >= {1'b0, r_cmd.s}) begin
                r_r_im <= S_BITS'(rs_im - {1'b0, r_cmd.s});
                r_q_im <= r_q_im + r_dq_im + QW'(1);
            end else begin
                r_r_im <= rs_im[S_BITS-1:0];
                r_q_im <= r_q_im + r_dq_im;
            end
        end
        if (out_we) begin
            r_o_re   <= w_re;
            r_o_im   <= w_im;
            r_o_idx  <= w_idx;
            r_o_last <= w_last;
        end
    end

    assign o_empty            = !r_ov;
    assign o_est_re           = r_o_re;
    assign o_est_im           = r_o_im;
    assign o_subcarrier_index = r_o_idx;
    assign o_frame_end        = r_o_last;

endmodule

FILE: rtl/core/pilot_ls_channel_estimator.sv
// Pilot LS channel estimator. The front takes one beat per cycle while full
// is low and writes pilot and tail commands into a four-entry command queue;
// the back works through one command at a time: a held estimate, or a pilot
// through the LS quotient division, the slope division and S interpolated beats.
// Synchronous reset sets N = 64, S = 4, position 0; a spacing write
// holds full high while the pilot phase is realigned.
module pilot_ls_channel_estimator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_idx,
    input  logic [pcle_pkg::N_BITS-1:0]            i_cfg_data,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [pcle_pkg::SAMPLE_BITS-1:0] i_rx_re,
    input  logic signed [pcle_pkg::SAMPLE_BITS-1:0] i_rx_im,
    input  logic signed [pcle_pkg::SAMPLE_BITS-1:0] i_ref_re,
    input  logic signed [pcle_pkg::SAMPLE_BITS-1:0] i_ref_im,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [pcle_pkg::EST_BITS-1:0]   o_est_re,
    output logic signed [pcle_pkg::EST_BITS-1:0]   o_est_im,
    output logic [pcle_pkg::IDX_BITS-1:0]          o_subcarrier_index,
    output logic                                   o_frame_end
);
    import pcle_pkg::*;

    t_cmd f_cmd;
    t_cmd q_cmd;
    logic f_valid;
    logic q_full;
    logic q_empty;
    logic q_pop;

    pcle_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_push(push), .o_full(full), .i_rx_re(i_rx_re),
        .i_rx_im(i_rx_im), .i_ref_re(i_ref_re), .i_ref_im(i_ref_im),
        .i_q_full(q_full), .o_cmd_valid(f_valid), .o_cmd(f_cmd)
    );

    pcle_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(f_valid), .i_data(f_cmd),
        .o_full(q_full), .i_rd(q_pop), .o_data(q_cmd), .o_empty(q_empty)
    );

    pcle_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(q_cmd), .i_cmd_empty(q_empty),
        .o_cmd_pop(q_pop), .i_pop(pop), .o_empty(empty), .o_est_re(o_est_re),
        .o_est_im(o_est_im), .o_subcarrier_index(o_subcarrier_index),
        .o_frame_end(o_frame_end)
    );

endmodule

FILE: tb/tb.sv
// Testbench for pilot_ls_channel_estimator: directed table plus random frames,
// checked beat by beat against an in-bench least-squares/interpolation predictor.
// Depends on pcle_pkg and the estimator RTL.
module tb;
    import pcle_pkg::*;

    typedef struct {
        logic signed [EST_BITS-1:0] re;
        logic signed [EST_BITS-1:0] im;
        logic [IDX_BITS-1:0]        idx;
        logic                       last;
    } t_est;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] rx_re, rx_im, ref_re, ref_im;
        logic                          chk;
        logic signed [EST_BITS-1:0]    est_re, est_im;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_cfg_we, i_cfg_idx;
    logic [N_BITS-1:0] i_cfg_data;
    logic push, full, empty, pop;
    logic signed [SAMPLE_BITS-1:0] i_rx_re, i_rx_im, i_ref_re, i_ref_im;
    logic signed [EST_BITS-1:0] o_est_re, o_est_im;
    logic [IDX_BITS-1:0] o_subcarrier_index;
    logic o_frame_end;

    pilot_ls_channel_estimator u_top (.*);

    t_est est_queue[$];
    int unsigned sc_count, spacing, position;
    longint prior_re, prior_im;
    int errors;
    bit hold_off;
    bit rows_check;
    logic signed [EST_BITS-1:0] row_re, row_im;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint ls_quotient(longint dot, longint den);
        bit neg;
        longint unsigned mag, q, r, lim;
        neg = dot < 0;
        mag = neg ? -dot : dot;
        lim = (64'd1 << (EST_BITS - 1)) - (neg ? 0 : 1);
        q = mag / den;
        r = mag % den;
        if (q > lim) q = lim;
        else begin
            for (int i = 0; i < FRAC_BITS; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q++;
                end
            end
            if (q > lim) q = lim;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void queue_est(longint re, longint im, int unsigned k, bit last);
        t_est e;
        e.re = EST_BITS'(re);
        e.im = EST_BITS'(im);
        e.idx = IDX_BITS'(k);
        e.last = last;
        est_queue.insert(est_queue.size(), e);
    endfunction

    // Returns the number of beats the subcarrier produces.
    function automatic int predict_subcarrier(longint yr, longint yi, longint xr, longint xi);
        int unsigned n, s, k;
        longint den, hr, hi, a;
        int cnt;
        cnt = 0;
        n = sc_count == 0 ? 1 : (sc_count > MAX_SUBCARRIERS ? MAX_SUBCARRIERS : sc_count);
        s = spacing == 0 ? 1 : (spacing > MAX_SPACING ? MAX_SPACING : spacing);
        k = position >= n ? 0 : position;
        if (k % s == 0) begin
            den = xr * xr + xi * xi;
            if (den == 0) begin
                hr = 1 << FRAC_BITS;
                hi = 0;
            end else begin
                hr = ls_quotient(yr * xr + yi * xi, den);
                hi = ls_quotient(yi * xr - yr * xi, den);
            end
            if (k > 0) begin
                for (int j = 0; j < s; j++) begin
                    a = s - j;
                    queue_est((a * prior_re + j * hr) / longint'(s),
                              (a * prior_im + j * hi) / longint'(s), k - s + j, 0);
                    cnt++;
                end
            end
            prior_re = hr;
            prior_im = hi;
            if (k + s >= n) begin
                queue_est(hr, hi, k, k == n - 1);
                cnt++;
            end
        end else if ((k / s) * s + s >= n) begin
            queue_est(prior_re, prior_im, k, k == n - 1);
            cnt++;
        end
        k++;
        if (k >= n) k = 0;
        position = k & 10'h3ff;
        return cnt;
    endfunction

    task automatic write_reg(logic idx, int unsigned value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= N_BITS'(value);
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_NUM_SC) sc_count = value & 11'h7ff;
        else spacing = value & 5'h1f;
        @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 0;
        while (est_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic send(logic signed [SAMPLE_BITS-1:0] yr, yi, xr, xi, int gap);
        int cnt;
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_rx_re <= yr;
        i_rx_im <= yi;
        i_ref_re <= xr;
        i_ref_im <= xi;
        do @(posedge i_clk); while (full);
        cnt = predict_subcarrier(yr, yi, xr, xi);
        if (rows_check && cnt > 0) begin
            est_queue[est_queue.size()-cnt].re = row_re;
            est_queue[est_queue.size()-cnt].im = row_im;
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rnd_sample();
        unique case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off requested by the sender.
    initial begin
        int wait_cycles;
        pop = 0;
        @(posedge i_rst_n);
        forever begin
            wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (hold_off) begin
                wait_cycles = 300;
                hold_off = 0;
            end
            if (wait_cycles > 0) begin
                pop <= 0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            pop <= 1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_est e;
        if (i_rst_n && pop && !empty) begin
            if (est_queue.size() == 0) begin
                $error("unexpected beat idx=%0d", o_subcarrier_index);
                errors++;
            end else begin
                e = est_queue.pop_front();
                if (o_est_re !== e.re) begin
                    $error("est_re exp %0d got %0d", e.re, o_est_re); errors++;
                end
                if (o_est_im !== e.im) begin
                    $error("est_im exp %0d got %0d", e.im, o_est_im); errors++;
                end
                if (o_subcarrier_index !== e.idx) begin
                    $error("subcarrier_index exp %0d got %0d", e.idx, o_subcarrier_index);
                    errors++;
                end
                if (o_frame_end !== e.last) begin
                    $error("frame_end exp %0d got %0d", e.last, o_frame_end); errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        int cfg_n[6] = '{16, 1, 0, 2047, 7, 40};
        int cfg_s[6] = '{4, 1, 0, 31, 8, 16};
        errors = 0;
        hold_off = 0;
        rows_check = 0;
        i_rst_n = 0;
        push = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_NUM_SC;
        i_cfg_data = 0;
        i_rx_re = 0; i_rx_im = 0; i_ref_re = 0; i_ref_im = 0;
        sc_count = 64; spacing = 4; position = 0; prior_re = 0; prior_im = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed table over N = 64, S = 4 after reset: zero ref, extremes.
        // The pilot at position 4 first repeats the estimate of position 0,
        // which is 1.0 because its reference is zero.
        rows = '{
            '{16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000, 0, 0, 0},
            '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0},
            '{16'sh8000, 16'sh8000, 16'sh0001, 16'sh0000, 0, 0, 0},
            '{16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000, 0, 0, 0},
            '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 1, 18'sh04000, 18'sh0},
            '{16'sh4000, 16'sh4000, 16'sh4000, 16'sh0000, 0, 0, 0},
            '{16'sh8000, 16'sh0000, 16'sh0000, 16'sh8000, 0, 0, 0},
            '{16'sh1234, 16'shedcb, 16'sh0000, 16'sh0001, 0, 0, 0},
            '{16'sh7fff, 16'sh0000, 16'sh0001, 16'sh0001, 0, 0, 0}
        };
        foreach (rows[i]) begin
            r = rows[i];
            rows_check = r.chk;
            row_re = r.est_re;
            row_im = r.est_im;
            send(r.rx_re, r.rx_im, r.ref_re, r.ref_im, $urandom_range(0, 2));
        end
        rows_check = 0;
        drain();

        // Lowering N below the current position starts a new frame.
        for (int c = 0; c < 6; c++) begin
            write_reg(CFG_NUM_SC, cfg_n[c]);
            write_reg(CFG_SPACING, cfg_s[c]);
            repeat (12) @(posedge i_clk);
            for (int i = 0; i < 37; i++) begin
                if (c == 2 && i == 10) hold_off = 1;
                send(rnd_sample(), rnd_sample(),
                     $urandom_range(0, 7) == 0 ? 16'sh0 : rnd_sample(),
                     $urandom_range(0, 7) == 0 ? 16'sh0 : rnd_sample(),
                     $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11));
                if (c == 4 && i == 20) drain();
            end
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
